// ===== hdl/scaled_modular_exponentiation_assert.svh =====
// ----------------------------------------------------------------------------
// Scaled modular exponentiation assertion macros
// Concurrent assertion forms used by the top module to check its own logic.
// ----------------------------------------------------------------------------
`ifndef SCALED_MODULAR_EXPONENTIATION_ASSERT_SVH
`define SCALED_MODULAR_EXPONENTIATION_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SME_ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("scaled_modular_exponentiation: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SME_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("scaled_modular_exponentiation: assertion failed");

`endif

// ===== hdl/sme_pkg.sv =====
// ----------------------------------------------------------------------------
// Scaled modular exponentiation package
// Field widths, register indexes, reset values and control and status structs.
// ----------------------------------------------------------------------------
package sme_pkg;

    localparam int BASE_W    = 60;
    localparam int EXP_W     = 32;
    localparam int POWER_W   = 60;
    localparam int CFG_W     = 60;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START   = 2'd1;

    localparam logic [CFG_W-1:0] MODULUS_RESET = 60'd1000228228228228247;
    localparam logic [CFG_W-1:0] START_RESET   = 60'd1232132166;

    typedef struct packed {
        logic start;
    } mul_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_stat_t;

endpackage

// ===== hdl/sme_cfg.sv =====
// ----------------------------------------------------------------------------
// Scaled modular exponentiation configuration registers
// Holds the modulus and the start multiplier, masked to the modulus width.
// ----------------------------------------------------------------------------
module sme_cfg
    import sme_pkg::*;
#(
    parameter int MW = 60
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [CFG_W-1:0]     wr_data,
    output logic [MW-1:0]        modulus,
    output logic [MW-1:0]        start_mult
);

    logic [MW-1:0] modulus_reg;
    logic [MW-1:0] start_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MW'(MODULUS_RESET);
            start_reg   <= MW'(START_RESET);
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_MODULUS: modulus_reg <= MW'(wr_data);
                REG_START:   start_reg   <= MW'(wr_data);
                default:     ;
            endcase
        end
    end

    assign modulus    = modulus_reg;
    assign start_mult = start_reg;

endmodule

// ===== hdl/sme_modmul.sv =====
// ----------------------------------------------------------------------------
// Scaled modular exponentiation bit-serial modular multiplier
// Computes (x * y) mod m, one bit of y per cycle, most significant first.
// ----------------------------------------------------------------------------
module sme_modmul
    import sme_pkg::*;
#(
    parameter int MW = 60,
    parameter int YW = 60
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  mul_ctl_t      ctl,
    input  logic [MW-1:0] x,
    input  logic [YW-1:0] y,
    input  logic [MW-1:0] m,
    output mul_stat_t     stat,
    output logic [MW-1:0] result
);

    localparam int CW = $clog2(YW + 1);

    logic [MW-1:0] acc_reg, acc_next;
    logic [MW-1:0] x_reg, x_next;
    logic [YW-1:0] y_reg, y_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;

    logic [MW+1:0] sum;
    logic [MW+1:0] m1;
    logic [MW+1:0] m2;
    logic [MW+1:0] red;

    // Since acc and x are both below m, 2*acc + x stays below 3*m.
    always_comb
    begin
        m1  = {2'b00, m};
        m2  = {1'b0, m, 1'b0};
        sum = {1'b0, acc_reg, 1'b0} + (y_reg[YW-1] ? {2'b00, x_reg} : '0);
        if (sum >= m2)
        begin
            red = sum - m2;
        end
        else if (sum >= m1)
        begin
            red = sum - m1;
        end
        else
        begin
            red = sum;
        end
    end

    always_comb
    begin
        acc_next  = acc_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctl.start)
        begin
            acc_next  = '0;
            x_next    = x;
            y_next    = y;
            cnt_next  = CW'(YW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = red[MW-1:0];
            y_next   = {y_reg[YW-2:0], 1'b0};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = acc_reg;

endmodule

// ===== hdl/scaled_modular_exponentiation.sv =====
// ----------------------------------------------------------------------------
// Scaled modular exponentiation
// Returns (start_multiplier * base^exponent) mod modulus per input item.
// ----------------------------------------------------------------------------
// The input channel (in_valid, in_stall, base, exponent) takes one item at a
// time; in_stall is high while an item is being worked on. The output channel
// (out_valid, out_stall, power) carries one result item per input item from
// an output register, so a new item is taken while a result still waits.
// Configuration must be written by the user through wr_en, wr_index and
// wr_data only while idle; the block itself does not enforce this. Index 0
// is the modulus and index 1 the start multiplier. All arithmetic runs on
// one bit-serial modular multiplier with a YW-bit y operand, YW being the
// larger of MOD_BITS and 60. An item costs two reductions, then one product
// per set exponent bit and one squaring per exponent bit below the highest
// set bit. The block returns to idle at the edge that loads the result.
// A modulus below two skips the multiplier and goes straight to loading a
// zero result.
// Reset restores the default modulus and start multiplier and empties the
// output register. While the receiver stalls, a finished result waits for
// the output register and the next item is held off.
// ----------------------------------------------------------------------------
module scaled_modular_exponentiation
    import sme_pkg::*;
#(
    parameter int MOD_BITS = 60,
    parameter int EXP_BITS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [CFG_W-1:0]     wr_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [BASE_W-1:0]    base,
    input  logic [EXP_W-1:0]     exponent,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [POWER_W-1:0]   power
);

    localparam int MW = MOD_BITS;
    localparam int YW = (MOD_BITS > BASE_W) ? MOD_BITS : BASE_W;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_RBASE  = 6'b000010,
        S_RSTART = 6'b000100,
        S_MUL    = 6'b001000,
        S_SQR    = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic [MW-1:0]       acc_reg, acc_next;
    logic [MW-1:0]       b_reg, b_next;
    logic [EXP_BITS-1:0] e_reg, e_next;
    logic                out_valid_reg, out_valid_next;
    logic [POWER_W-1:0]  power_reg, power_next;
    logic                do_step;

    logic [MW-1:0] modulus;
    logic [MW-1:0] start_mult;

    mul_ctl_t      mul_ctl;
    mul_stat_t     mul_stat;
    logic [MW-1:0] mul_x;
    logic [YW-1:0] mul_y;
    logic [MW-1:0] mul_result;

    sme_cfg #(
        .MW(MW)
    ) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .modulus    (modulus),
        .start_mult (start_mult)
    );

    sme_modmul #(
        .MW(MW),
        .YW(YW)
    ) u_modmul (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mul_ctl),
        .x      (mul_x),
        .y      (mul_y),
        .m      (modulus),
        .stat   (mul_stat),
        .result (mul_result)
    );

    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        b_next         = b_reg;
        e_next         = e_reg;
        out_valid_next = out_valid_reg;
        power_next     = power_reg;
        mul_ctl.start  = 1'b0;
        mul_x          = acc_reg;
        mul_y          = YW'(b_reg);
        do_step        = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    e_next = EXP_BITS'(exponent);
                    if (modulus < MW'(2))
                    begin
                        acc_next   = '0;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        // The base is reduced as the product 1 * base.
                        mul_ctl.start = 1'b1;
                        mul_x         = MW'(1);
                        mul_y         = YW'(base);
                        state_next    = S_RBASE;
                    end
                end
            end
            S_RBASE:
            begin
                if (mul_stat.done)
                begin
                    b_next        = mul_result;
                    mul_ctl.start = 1'b1;
                    mul_x         = MW'(1);
                    mul_y         = YW'(start_mult);
                    state_next    = S_RSTART;
                end
            end
            S_RSTART:
            begin
                if (mul_stat.done)
                begin
                    acc_next = mul_result;
                    do_step  = 1'b1;
                end
            end
            S_MUL:
            begin
                if (mul_stat.done)
                begin
                    acc_next = mul_result;
                    // With no higher exponent bits left, further squarings
                    // cannot change the result.
                    if ((e_reg >> 1) == '0)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        mul_ctl.start = 1'b1;
                        mul_x         = b_reg;
                        mul_y         = YW'(b_reg);
                        state_next    = S_SQR;
                    end
                end
            end
            S_SQR:
            begin
                if (mul_stat.done)
                begin
                    b_next  = mul_result;
                    e_next  = e_reg >> 1;
                    do_step = 1'b1;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    power_next     = POWER_W'(acc_reg);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Pick the next operation from the lowest remaining exponent bit.
        if (do_step)
        begin
            if (e_next == '0)
            begin
                state_next = S_FINISH;
            end
            else if (e_next[0])
            begin
                mul_ctl.start = 1'b1;
                mul_x         = acc_next;
                mul_y         = YW'(b_next);
                state_next    = S_MUL;
            end
            else
            begin
                mul_ctl.start = 1'b1;
                mul_x         = b_next;
                mul_y         = YW'(b_next);
                state_next    = S_SQR;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        b_reg     <= b_next;
        e_reg     <= e_next;
        power_reg <= power_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign power     = power_reg;

`include "scaled_modular_exponentiation_assert.svh"

    `SME_ASSERT_IMPL(a_done_in_work, clk, rst_n, mul_stat.done,
        (state_reg == S_RBASE || state_reg == S_RSTART ||
         state_reg == S_MUL || state_reg == S_SQR))

    `SME_ASSERT_IMPL(a_mul_running, clk, rst_n,
        (state_reg == S_MUL || state_reg == S_SQR),
        (mul_stat.busy || mul_stat.done))

    `SME_ASSERT_NEXT(a_finish_loads, clk, rst_n,
        (state_reg == S_FINISH && (!out_valid_reg || !out_stall)),
        (out_valid_reg && state_reg == S_IDLE))

endmodule
